[rtl/core/aar_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package aar_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int SIZE_W  = 9;
    localparam int COLOR_W = 8;
    localparam int COORD_W = 8;
    localparam int PIXEL_W = 3 * COLOR_W;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

    // the reciprocal is multiplied in chunks of 2**CHUNK_LOG bits
    localparam int CHUNK_LOG = 4;
    localparam int CHUNK_W   = 1 << CHUNK_LOG;

    typedef enum logic [1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_DST_WIDTH  = 2'd2,
        REG_DST_HEIGHT = 2'd3
    } cfg_index_t;

    typedef enum logic {
        MODE_LOAD    = 1'b0,
        MODE_COMPUTE = 1'b1
    } mode_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

[rtl/core/area_average_image_resizer.sv]
`timescale 1ns / 1ps
`default_nettype none

// Area-averaging RGB888 resizer.
// Input channel (in_valid/in_ready): a beat with mode load writes one source
// pixel into the image memory and gives no result. A beat with
// mode compute names one destination pixel; its averaged color leaves on the
// output channel (out_valid/out_ready) as one beat.
// A compute beat walks every source cell that the pixel covers, one memory
// read per cycle; the serial divider then forms the reciprocal, and in_ready
// rises together with out_valid. The first compute after reset or after a
// size register write also runs the divider twice for the scale factors.
// Size registers are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, and the block itself does not enforce this.
// The block takes one compute at a time; in_ready is high whenever it is idle,
// also while a result waits in the output register. A stalled receiver holds
// the result; the next compute finishes and then waits until the register
// frees. Reset sets all four size registers to 256; the image memory is not
// cleared, so every pixel must be loaded before it is used.

module area_average_image_resizer #(
    parameter int MAX_WIDTH  = aar_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = aar_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = aar_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [aar_pkg::SIZE_W-1:0]    cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          mode,
    input  wire logic [aar_pkg::COORD_W-1:0]   pos_x,
    input  wire logic [aar_pkg::COORD_W-1:0]   pos_y,
    input  wire logic [aar_pkg::COLOR_W-1:0]   red_in,
    input  wire logic [aar_pkg::COLOR_W-1:0]   green_in,
    input  wire logic [aar_pkg::COLOR_W-1:0]   blue_in,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [aar_pkg::COLOR_W-1:0]   red_out,
    output logic      [aar_pkg::COLOR_W-1:0]   green_out,
    output logic      [aar_pkg::COLOR_W-1:0]   blue_out
);

    localparam int F      = FRAC_BITS;
    localparam int SZ_W   = aar_pkg::SIZE_W;
    localparam int CW     = aar_pkg::COLOR_W;
    localparam int WS_W   = SZ_W + F;
    localparam int PP_W   = WS_W + 10;
    localparam int P1_W   = F + 1;
    localparam int WGT_W  = F + 20;
    localparam int ACC_W  = WGT_W + CW;
    localparam int INV_W  = 2 * F + 1;
    localparam int NCH    = (INV_W + aar_pkg::CHUNK_W - 1) / aar_pkg::CHUNK_W;
    localparam int INV_PW = NCH * aar_pkg::CHUNK_W;
    localparam int CK_W   = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PROD_W = ACC_W + INV_PW;
    localparam int Q_W    = PROD_W - F;
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CR_W   = PP_W - F;

    localparam logic [PP_W-1:0]   ONE_P = PP_W'(1) << F;
    localparam logic [F+CW-1:0]   LIM   = {8'd255, {F{1'b0}}};
    localparam logic [Q_W-1:0]    HALF  = Q_W'(1) << (F - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCALE_W, S_SCALE_H, S_SETUP, S_WALK, S_DRAIN,
        S_INV, S_MUL, S_MWAIT, S_FIN
    } state_t;

    function automatic logic [SZ_W-1:0] eff_size(logic [SZ_W-1:0] v, int max_v);
        logic [SZ_W-1:0] r;
        if (v == '0)
            r = SZ_W'(1);
        else if (32'(v) > max_v)
            r = SZ_W'(max_v);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [P1_W-1:0] overlap(logic [PP_W-1:0] s, logic first,
                                                logic [PP_W-1:0] s1,
                                                logic [PP_W-1:0] s2);
        logic [PP_W-1:0] a;
        logic [PP_W-1:0] d;
        logic [PP_W-1:0] fl2;
        logic [P1_W-1:0] p;
        a   = ONE_P - PP_W'(s1[F-1:0]);
        d   = s2 - s1;
        fl2 = {s2[PP_W-1:F], {F{1'b0}}};
        if (first)
            p = (d < a) ? d[P1_W-1:0] : a[P1_W-1:0];
        else if (s == fl2)
            p = P1_W'(s2[F-1:0]);
        else
            p = ONE_P[P1_W-1:0];
        return p;
    endfunction

    function automatic logic [AW-1:0] addr_of(logic [CR_W-1:0] row, logic [CR_W-1:0] col);
        return AW'(32'(row) * 32'(MAX_WIDTH) + 32'(col));
    endfunction

    function automatic logic [CW-1:0] finish(logic [PROD_W-1:0] p);
        logic [Q_W-1:0] q;
        logic [Q_W-1:0] r;
        q = p[PROD_W-1:F];
        if (q > Q_W'(LIM))
            q = Q_W'(LIM);
        r = (q + HALF) >> F;
        return r[CW-1:0];
    endfunction

    // configuration
    logic [SZ_W-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic            scale_ok_reg;
    logic [WS_W-1:0] ws_reg, hs_reg;

    state_t state_reg, state_next;

    logic [CW-1:0]   px_reg, py_reg;
    logic [PP_W-1:0] sx1_reg, sx2_reg, sy1_reg, sy2_reg, sx_reg, sy_reg;
    logic            fx_reg, fy_reg;

    // cell pipeline
    logic                v1_reg, oob1_reg, v2_reg;
    logic [2*P1_W-1:0]   pcprod_reg;
    logic [P1_W+CW-1:0]  rp_reg, gp_reg, bp_reg;
    logic [P1_W-1:0]     pc2_reg;
    logic [ACC_W-1:0]    racc_reg, gacc_reg, bacc_reg;
    logic [WGT_W-1:0]    wgt_reg;

    // reciprocal multiply
    logic [INV_W-1:0]            inv_reg;
    logic [1:0]                  col_reg, mcol_reg;
    logic [CK_W-1:0]             chk_reg, mchk_reg;
    logic                        mv_reg;
    logic [ACC_W+aar_pkg::CHUNK_W-1:0] mp_reg;
    logic [PROD_W-1:0]           pr_reg, pg_reg, pb_reg;

    logic            div_go_reg;
    logic            out_valid_reg;
    logic [CW-1:0]   red_reg, green_reg, blue_reg;

    // divider
    logic [INV_W-1:0]   div_num;
    logic [WGT_W-1:0]   div_den;
    logic [INV_W-1:0]   div_quot;
    aar_pkg::div_stat_t div_stat;

    // memory
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr, ram_raddr;
    logic [aar_pkg::PIXEL_W-1:0] ram_rdata;

    logic [SZ_W-1:0] eff_sw, eff_sh, eff_dw, eff_dh;
    logic            in_acc;

    // walk step
    logic [P1_W-1:0] xp, yp;
    logic [PP_W-1:0] sx_n, sy_n;
    logic [CR_W-1:0] cell_col, cell_row;
    logic            cell_oob;

    // stage two
    logic [P1_W-1:0]             pc;
    logic [aar_pkg::PIXEL_W-1:0] pix;

    logic [INV_PW-1:0]          inv_pad;
    logic [ACC_W-1:0]           csel;
    logic [PROD_W-1:0]          mp_shift;

    assign eff_sw = eff_size(src_w_reg, MAX_WIDTH);
    assign eff_sh = eff_size(src_h_reg, MAX_HEIGHT);
    assign eff_dw = eff_size(dst_w_reg, MAX_WIDTH);
    assign eff_dh = eff_size(dst_h_reg, MAX_HEIGHT);

    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;

    assign ram_we    = in_acc && (mode == aar_pkg::MODE_LOAD)
                       && (32'(pos_x) < MAX_WIDTH) && (32'(pos_y) < MAX_HEIGHT);
    assign ram_waddr = addr_of(CR_W'(pos_y), CR_W'(pos_x));

    always_comb
    begin
        unique case (state_reg)
            S_SCALE_W:
            begin
                div_num = INV_W'({eff_sw, {F{1'b0}}});
                div_den = WGT_W'(eff_dw);
            end
            S_SCALE_H:
            begin
                div_num = INV_W'({eff_sh, {F{1'b0}}});
                div_den = WGT_W'(eff_dh);
            end
            default:
            begin
                div_num = INV_W'(1) << (2 * F);
                div_den = wgt_reg;
            end
        endcase
    end

    aar_div #(
        .NUM_W (INV_W),
        .DEN_W (WGT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_go_reg),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_quot),
        .stat  (div_stat)
    );

    assign xp       = overlap(sx_reg, fx_reg, sx1_reg, sx2_reg);
    assign yp       = overlap(sy_reg, fy_reg, sy1_reg, sy2_reg);
    assign sx_n     = sx_reg + ONE_P;
    assign sy_n     = sy_reg + ONE_P;
    assign cell_col = sx_reg[PP_W-1:F];
    assign cell_row = sy_reg[PP_W-1:F];
    assign cell_oob = (32'(cell_col) >= MAX_WIDTH) || (32'(cell_row) >= MAX_HEIGHT);
    assign ram_raddr = addr_of(cell_row, cell_col);

    aar_ram #(
        .WIDTH (aar_pkg::PIXEL_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_image (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({red_in, green_in, blue_in}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pc  = pcprod_reg[F+P1_W-1:F];
    assign pix = oob1_reg ? '0 : ram_rdata;

    assign inv_pad  = INV_PW'(inv_reg);
    assign mp_shift = PROD_W'(mp_reg) << {mchk_reg, {aar_pkg::CHUNK_LOG{1'b0}}};

    always_comb
    begin
        case (col_reg)
            2'd0:    csel = racc_reg;
            2'd1:    csel = gacc_reg;
            default: csel = bacc_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (mode == aar_pkg::MODE_COMPUTE))
                    state_next = scale_ok_reg ? S_SETUP : S_SCALE_W;
            end
            S_SCALE_W:
            begin
                if (div_stat.done)
                    state_next = S_SCALE_H;
            end
            S_SCALE_H:
            begin
                if (div_stat.done)
                    state_next = S_SETUP;
            end
            S_SETUP:
            begin
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if ((sx_n >= sx2_reg) && (sy_n >= sy2_reg))
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                    state_next = (wgt_reg == '0) ? S_FIN : S_INV;
            end
            S_INV:
            begin
                if (div_stat.done)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                if ((col_reg == 2'd2) && (32'(chk_reg) == NCH - 1))
                    state_next = S_MWAIT;
            end
            S_MWAIT:
            begin
                if (!mv_reg)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            src_w_reg     <= aar_pkg::SIZE_RESET;
            src_h_reg     <= aar_pkg::SIZE_RESET;
            dst_w_reg     <= aar_pkg::SIZE_RESET;
            dst_h_reg     <= aar_pkg::SIZE_RESET;
            scale_ok_reg  <= 1'b0;
            ws_reg        <= '0;
            hs_reg        <= '0;
            px_reg        <= '0;
            py_reg        <= '0;
            sx1_reg       <= '0;
            sx2_reg       <= '0;
            sy1_reg       <= '0;
            sy2_reg       <= '0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            fx_reg        <= 1'b0;
            fy_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            oob1_reg      <= 1'b0;
            pcprod_reg    <= '0;
            v2_reg        <= 1'b0;
            rp_reg        <= '0;
            gp_reg        <= '0;
            bp_reg        <= '0;
            pc2_reg       <= '0;
            racc_reg      <= '0;
            gacc_reg      <= '0;
            bacc_reg      <= '0;
            wgt_reg       <= '0;
            inv_reg       <= '0;
            col_reg       <= '0;
            chk_reg       <= '0;
            mcol_reg      <= '0;
            mchk_reg      <= '0;
            mv_reg        <= 1'b0;
            mp_reg        <= '0;
            pr_reg        <= '0;
            pg_reg        <= '0;
            pb_reg        <= '0;
            div_go_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            red_reg       <= '0;
            green_reg     <= '0;
            blue_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            div_go_reg <= 1'b0;

            if (cfg_we)
            begin
                scale_ok_reg <= 1'b0;
                unique case (cfg_index)
                    aar_pkg::REG_SRC_WIDTH:  src_w_reg <= cfg_data;
                    aar_pkg::REG_SRC_HEIGHT: src_h_reg <= cfg_data;
                    aar_pkg::REG_DST_WIDTH:  dst_w_reg <= cfg_data;
                    aar_pkg::REG_DST_HEIGHT: dst_h_reg <= cfg_data;
                    default:                 src_w_reg <= src_w_reg;
                endcase
            end

            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && (mode == aar_pkg::MODE_COMPUTE))
                    begin
                        px_reg     <= pos_x;
                        py_reg     <= pos_y;
                        div_go_reg <= !scale_ok_reg;
                    end
                end
                S_SCALE_W:
                begin
                    if (div_stat.done)
                    begin
                        ws_reg     <= div_quot[WS_W-1:0];
                        div_go_reg <= 1'b1;
                    end
                end
                S_SCALE_H:
                begin
                    if (div_stat.done)
                    begin
                        hs_reg       <= div_quot[WS_W-1:0];
                        scale_ok_reg <= 1'b1;
                    end
                end
                S_SETUP:
                begin
                    sx1_reg  <= PP_W'(px_reg) * PP_W'(ws_reg);
                    sx2_reg  <= (PP_W'(px_reg) + PP_W'(1)) * PP_W'(ws_reg);
                    sy1_reg  <= PP_W'(py_reg) * PP_W'(hs_reg);
                    sy2_reg  <= (PP_W'(py_reg) + PP_W'(1)) * PP_W'(hs_reg);
                    sx_reg   <= {PP_W'(PP_W'(px_reg) * PP_W'(ws_reg)) >> F} << F;
                    sy_reg   <= {PP_W'(PP_W'(py_reg) * PP_W'(hs_reg)) >> F} << F;
                    fx_reg   <= 1'b1;
                    fy_reg   <= 1'b1;
                    racc_reg <= '0;
                    gacc_reg <= '0;
                    bacc_reg <= '0;
                    wgt_reg  <= '0;
                end
                S_WALK:
                begin
                    // advance across the row, then drop to the next row
                    if (sx_n >= sx2_reg)
                    begin
                        sx_reg <= {sx1_reg[PP_W-1:F], {F{1'b0}}};
                        fx_reg <= 1'b1;
                        sy_reg <= sy_n;
                        fy_reg <= 1'b0;
                    end
                    else
                    begin
                        sx_reg <= sx_n;
                        fx_reg <= 1'b0;
                    end
                end
                S_DRAIN:
                begin
                    if (!v1_reg && !v2_reg)
                    begin
                        div_go_reg <= (wgt_reg != '0);
                        pr_reg     <= '0;
                        pg_reg     <= '0;
                        pb_reg     <= '0;
                    end
                end
                S_INV:
                begin
                    if (div_stat.done)
                    begin
                        inv_reg <= div_quot;
                        col_reg <= '0;
                        chk_reg <= '0;
                    end
                end
                S_MUL:
                begin
                    if (32'(chk_reg) == NCH - 1)
                    begin
                        chk_reg <= '0;
                        col_reg <= col_reg + 2'd1;
                    end
                    else
                    begin
                        chk_reg <= chk_reg + CK_W'(1);
                    end
                end
                S_MWAIT:
                begin
                end
                S_FIN:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        red_reg       <= finish(pr_reg);
                        green_reg     <= finish(pg_reg);
                        blue_reg      <= finish(pb_reg);
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            // cell pipeline: issue, weight and read, accumulate
            v1_reg     <= (state_reg == S_WALK);
            oob1_reg   <= cell_oob;
            pcprod_reg <= xp * yp;

            v2_reg  <= v1_reg;
            pc2_reg <= pc;
            rp_reg  <= pix[23:16] * pc;
            gp_reg  <= pix[15:8] * pc;
            bp_reg  <= pix[7:0] * pc;

            if (v2_reg)
            begin
                racc_reg <= racc_reg + ACC_W'(rp_reg);
                gacc_reg <= gacc_reg + ACC_W'(gp_reg);
                bacc_reg <= bacc_reg + ACC_W'(bp_reg);
                wgt_reg  <= wgt_reg + WGT_W'(pc2_reg);
            end

            // chunked multiply by the reciprocal
            mv_reg   <= (state_reg == S_MUL);
            mcol_reg <= col_reg;
            mchk_reg <= chk_reg;
            mp_reg   <= csel * inv_pad[chk_reg * aar_pkg::CHUNK_W +: aar_pkg::CHUNK_W];

            if (mv_reg)
            begin
                case (mcol_reg)
                    2'd0:    pr_reg <= pr_reg + mp_shift;
                    2'd1:    pg_reg <= pg_reg + mp_shift;
                    default: pb_reg <= pb_reg + mp_shift;
                endcase
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;

    a_walk_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> (state_reg == S_DRAIN) || (state_reg == S_WALK))
        else $error("cell pipeline active outside the walk");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !div_stat.busy)
        else $error("divider busy while idle");

    a_compute_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (mode == aar_pkg::MODE_COMPUTE)) |=> (state_reg != S_IDLE))
        else $error("compute beat did not start work");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result appeared outside the finish step");

endmodule

`default_nettype wire

[rtl/core/aar_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module aar_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/core/aar_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module aar_div #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 36
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [NUM_W-1:0]    num,
    input  wire logic [DEN_W-1:0]    den,
    output logic      [NUM_W-1:0]    quot,
    output aar_pkg::div_stat_t       stat
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] qn_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, qn_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qn_reg   <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                qn_reg   <= num;
                rem_reg  <= '0;
                den_reg  <= den;
                cnt_reg  <= CNT_W'(NUM_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                // shift the numerator out, the quotient bit in
                qn_reg  <= {qn_reg[NUM_W-2:0], fits};
                rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quot      = qn_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire
